// ----- rtl/core/command_event_timer_table_defines.svh -----
// Assertion macros for the command event timer table.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef COMMAND_EVENT_TIMER_TABLE_DEFINES_SVH
`define COMMAND_EVENT_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CETT_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cett assertion failed");

// Next-cycle implication, checked outside reset.
`define CETT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cett assertion failed");

`endif

// ----- rtl/core/cett_pkg.sv -----
// Types and constants for the command event timer table.
// No dependencies; used by command_event_timer_table.
`timescale 1ns / 1ps

package cett_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  command;
    logic [23:0] seconds;
    logic        reload_mode;
  } in_item_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_command;
    status_e    status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [23:0] remaining;
    logic [23:0] reload_value;
    logic        reload;
  } slot_t;

endpackage

// ----- rtl/core/command_event_timer_table.sv -----
// Command event timer table: slot memory, scan sequencer and output register.
// Depends on cett_pkg and command_event_timer_table_defines.svh.
`timescale 1ns / 1ps
`include "command_event_timer_table_defines.svh"

// Usage
// The input channel takes one item per command: a tick, a set or a remove.
// The block raises in_stall_o from the cycle after acceptance until the item
// is fully handled, so only one item is in work at a time. Results leave
// through a single output register on the output channel; each item's final
// result carries last.
// Scan: every tick, set or remove walks the slot memory one slot per cycle
// while the output register can take results, through a single shared
// decrement and compare unit, with a registered memory read. In a tick,
// each firing slot after the first must find the output register free. A
// set or remove ends early when its slot is found. An item with the unused
// action code is taken without raising in_stall_o and yields no result.
// When the receiver stalls, the scan holds on the current slot until the
// output register drains, so no result is lost.
// Reset empties the table at once through per-slot valid flags; an invalid
// slot reads as all zero, so no clearing pass is needed.
module command_event_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cett_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cett_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_RESP
  } state_e;

  // Slot storage. The memory itself has no reset; valid flags mark written slots.
  cett_pkg::slot_t mem_q [SLOTS];
  cett_pkg::slot_t rd_q;
  logic            rd_vld_q;
  logic [SLOTS-1:0] vld_q;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [1:0]        act_q, act_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [23:0]       secs_q, secs_d;
  logic              mode_q, mode_d;
  logic              pend_q, pend_d;
  logic [7:0]        ptag_q, ptag_d;
  logic [cett_pkg::CntW-1:0] cnt_q, cnt_d;
  logic              idle_found_q, idle_found_d;
  logic [IdxW-1:0]   idle_idx_q, idle_idx_d;
  logic [IdxW-1:0]   tgt_q, tgt_d;
  logic              wr_q, wr_d;
  cett_pkg::slot_t   wdata_q, wdata_d;
  cett_pkg::status_e status_q, status_d;
  logic              out_valid_q, out_valid_d;
  cett_pkg::out_item_t out_q, out_d;

  logic              out_free;
  logic              emit;
  cett_pkg::out_item_t emit_item;
  logic [IdxW-1:0]   rd_addr;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  cett_pkg::slot_t   mem_wdata;
  cett_pkg::slot_t   cur;
  logic [23:0]       dec;
  logic              fire;
  logic              advance;
  logic              is_last;

  // The slot being examined; a never-written slot reads as idle with tag zero.
  assign cur     = rd_vld_q ? rd_q : '0;
  // The shared unit: one 24-bit decrement and zero test per cycle.
  assign dec     = cur.remaining - 24'd1;
  assign fire    = (cur.remaining != 24'd0) && (dec == 24'd0);
  assign is_last = (idx_q == LastIdx);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    act_d        = act_q;
    cmd_d        = cmd_q;
    secs_d       = secs_q;
    mode_d       = mode_q;
    pend_d       = pend_q;
    ptag_d       = ptag_q;
    cnt_d        = cnt_q;
    idle_found_d = idle_found_q;
    idle_idx_d   = idle_idx_q;
    tgt_d        = tgt_q;
    wr_d         = wr_q;
    wdata_d      = wdata_q;
    status_d     = status_q;
    rd_addr      = '0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = cur;
    emit         = 1'b0;
    emit_item    = '0;
    advance      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d        = in_item_i.action;
          cmd_d        = in_item_i.command;
          secs_d       = in_item_i.seconds;
          mode_d       = in_item_i.reload_mode;
          idx_d        = '0;
          pend_d       = 1'b0;
          cnt_d        = '0;
          idle_found_d = 1'b0;
          if (in_item_i.action == cett_pkg::ACT_TICK ||
              in_item_i.action == cett_pkg::ACT_SET ||
              in_item_i.action == cett_pkg::ACT_REMOVE) begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        case (act_q)
          cett_pkg::ACT_TICK: begin
            if (fire) begin
              if (pend_q && cnt_q < cett_pkg::CntW'(cett_pkg::MaxResults)) begin
                // A later firing proves the held one was not the final result.
                if (out_free) begin
                  emit      = 1'b1;
                  emit_item = '{fired: 1'b1, fired_command: ptag_q,
                                status: cett_pkg::ST_OK, last: 1'b0};
                  ptag_d    = cur.tag;
                  cnt_d     = cnt_q + 1'b1;
                end else begin
                  advance = 1'b0;
                end
              end else if (!pend_q) begin
                pend_d = 1'b1;
                ptag_d = cur.tag;
                cnt_d  = cett_pkg::CntW'(1);
              end
            end
            if (cur.remaining != 24'd0) begin
              mem_we              = advance;
              mem_wdata.remaining = fire ? (cur.reload ? cur.reload_value : 24'd0) : dec;
            end
            if (advance && is_last) begin
              state_d = S_FLUSH;
            end
          end

          cett_pkg::ACT_SET: begin
            wdata_d = '{tag: cmd_q, remaining: secs_q, reload_value: secs_q,
                        reload: mode_q};
            if (cur.tag == cmd_q) begin
              state_d  = S_RESP;
              wr_d     = 1'b1;
              tgt_d    = idx_q;
              status_d = cett_pkg::ST_OK;
            end else begin
              if (!idle_found_q && cur.remaining == 24'd0) begin
                idle_found_d = 1'b1;
                idle_idx_d   = idx_q;
              end
              if (is_last) begin
                state_d  = S_RESP;
                wr_d     = idle_found_d;
                tgt_d    = idle_idx_d;
                status_d = idle_found_d ? cett_pkg::ST_OK : cett_pkg::ST_FULL;
              end
            end
          end

          cett_pkg::ACT_REMOVE: begin
            if (cur.remaining != 24'd0 && cur.tag == cmd_q) begin
              state_d           = S_RESP;
              wr_d              = 1'b1;
              tgt_d             = idx_q;
              wdata_d           = cur;
              wdata_d.remaining = 24'd0;
              status_d          = cett_pkg::ST_OK;
            end else if (is_last) begin
              state_d  = S_RESP;
              wr_d     = 1'b0;
              status_d = cett_pkg::ST_NOT_FOUND;
            end
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase

        // Read one slot ahead; on a hold, read the current slot again.
        if (advance && !is_last) begin
          idx_d   = idx_q + 1'b1;
          rd_addr = idx_q + 1'b1;
        end else begin
          rd_addr = idx_q;
        end
      end

      S_FLUSH: begin
        if (!pend_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_item = '{fired: 1'b1, fired_command: ptag_q,
                        status: cett_pkg::ST_OK, last: 1'b1};
          pend_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = '{fired: 1'b0, fired_command: 8'd0,
                        status: status_q, last: 1'b1};
          mem_we    = wr_q;
          mem_waddr = tgt_q;
          mem_wdata = wdata_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
      out_d       = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      act_q        <= '0;
      pend_q       <= 1'b0;
      cnt_q        <= '0;
      idle_found_q <= 1'b0;
      wr_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      act_q        <= act_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      idle_found_q <= idle_found_d;
      wr_q         <= wr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    secs_q     <= secs_d;
    mode_q     <= mode_d;
    ptag_q     <= ptag_d;
    idle_idx_q <= idle_idx_d;
    tgt_q      <= tgt_d;
    wdata_q    <= wdata_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A fired result always reports status ok.
  `CETT_ASSERT_NOW(a_fired_ok, clk_i, rst_ni, out_valid_o && out_item_o.fired,
                   out_item_o.status == cett_pkg::ST_OK)
  // Set and remove answers are single results, so they always close the item.
  `CETT_ASSERT_NOW(a_resp_last, clk_i, rst_ni, out_valid_o && !out_item_o.fired,
                   out_item_o.last)
  // The reported firing count never passes the result limit.
  `CETT_ASSERT_NOW(a_cnt_cap, clk_i, rst_ni, 1'b1,
                   cnt_q <= cett_pkg::CntW'(cett_pkg::MaxResults))
  // A real command keeps the block busy in the cycle after acceptance.
  `CETT_ASSERT_NEXT(a_busy, clk_i, rst_ni,
                    in_valid_i && !in_stall_o &&
                    (in_item_i.action == cett_pkg::ACT_TICK ||
                     in_item_i.action == cett_pkg::ACT_SET ||
                     in_item_i.action == cett_pkg::ACT_REMOVE),
                    in_stall_o)

endmodule
